// ===== design/allocation_tracker_hash_assert.svh =====
// Assertion macros for the allocation tracker.
// Used by allocation_tracker_hash; expects aclk and aresetn in scope.
`ifndef ALLOCATION_TRACKER_HASH_ASSERT_SVH
`define ALLOCATION_TRACKER_HASH_ASSERT_SVH

// same-cycle implication
`define ATH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ath_pkg.sv =====
// Shared types and constants of the allocation tracker.
// No dependencies.
package ath_pkg;

    localparam int unsigned PTR_ENTRIES_DEF    = 4096;
    localparam int unsigned CALLER_ENTRIES_DEF = 1024;
    localparam logic [31:0] HASH_MUL           = 32'd699343;

    localparam int unsigned S_TDATA_W   = 168;
    localparam int unsigned M_TDATA_W   = 424;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned PTR_DATA_W  = 96;   // owner, bytes
    localparam int unsigned CALL_DATA_W = 160;  // count, live, sum

    localparam logic [47:0] HEAP_BYTES_RST = 48'd1000000000;
    localparam logic [15:0] INTERVAL_RST   = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAP_BASE  = 2'd0,
        REG_HEAP_BYTES = 2'd1,
        REG_INTERVAL   = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FOREIGN   = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_TRACKED   = 3'd4,
        ST_UNKNOWN   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK0, S_CHK1, S_ADDR, S_PHASH, S_PREAD, S_PCHK,
        S_CHASH, S_CREAD, S_CCHK, S_COMMIT, S_OUT
    } state_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } look_t;

endpackage

// ===== design/allocation_tracker_hash.sv =====
// Allocation tracker top level: bump allocator with pointer and caller hash tables.
// Depends on ath_pkg, ath_table and allocation_tracker_hash_assert.svh.
//
// One request at a time. An allocate checks heap space, computes the aligned address,
// probes the pointer table and then the caller table, and commits; a free checks the
// address range, probes the pointer table and then the caller table, and commits. A
// foreign free or an allocate refused for heap or table space exits after the range
// checks; an address already tracked or an untracked free exits after its probe. The
// probe loops do one table memory read and compare per step; a result held by m_tready
// low stalls the block. After reset both tables are swept clear, and a report_interval
// write realigns the report counter; no request is taken meanwhile. Table depths must be
// powers of two.
`include "allocation_tracker_hash_assert.svh"
module allocation_tracker_hash #(
    parameter int unsigned PTR_ENTRIES    = ath_pkg::PTR_ENTRIES_DEF,
    parameter int unsigned CALLER_ENTRIES = ath_pkg::CALLER_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // caller_id, request_bytes, align_log2, free_address
    input  logic [ath_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, granted_address, caller_times, caller_outstanding, caller_accumulated,
    // grand_times, total_outstanding, total_accumulated, foreign_free_count, report_due
    output logic [ath_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [ath_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ath_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ath_pkg::*;

    localparam int unsigned PIW = $clog2(PTR_ENTRIES);
    localparam int unsigned CIW = $clog2(CALLER_ENTRIES);
    localparam logic [PIW-1:0] PMUL = PIW'(HASH_MUL);
    localparam logic [CIW-1:0] CMUL = CIW'(HASH_MUL);
    localparam logic [PIW:0] PTR_FULL  = (PIW+1)'(PTR_ENTRIES);
    localparam logic [CIW:0] CALL_FULL = (CIW+1)'(CALLER_ENTRIES);

    state_t state_reg, state_next;

    logic [63:0] heap_base_reg;
    logic [47:0] heap_bytes_reg;
    logic [15:0] interval_reg;
    logic [63:0] bump_reg;
    logic [PIW:0] ptr_used_reg;
    logic [CIW:0] caller_used_reg;
    logic [31:0] gcount_reg;
    logic [63:0] glive_reg, gsum_reg;
    logic [31:0] bad_reg;
    logic [15:0] rep_cnt_reg;

    logic        mod_busy_reg;
    logic [4:0]  mod_cnt_reg;
    logic [15:0] mod_rem_reg;
    logic [31:0] mod_dvd_reg;
    logic [16:0] mod_t;

    logic        cmd_reg;
    logic [63:0] caller_reg, faddr_reg, off_reg, rel_reg, addr_reg, key_reg;
    logic [31:0] nbytes_reg, pbytes_reg;
    logic [3:0]  align_reg;
    logic [15:0] pad_reg;
    logic [32:0] need_reg;
    logic [PIW-1:0] ppos_reg, pcnt_reg;
    logic [CIW-1:0] cpos_reg, ccnt_reg;
    logic        cnew_reg;
    logic [31:0] cap_count_reg;
    logic [63:0] cap_live_reg, cap_sum_reg;

    status_t     r_status_reg;
    logic [63:0] r_granted_reg, r_co_reg, r_ca_reg;
    logic [31:0] r_ct_reg;
    logic        r_due_reg;

    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    look_t                  p_look, c_look;
    logic [PTR_DATA_W-1:0]  p_rd_data, p_wr_data;
    logic [CALL_DATA_W-1:0] c_rd_data, c_wr_data;
    logic                   p_busy, c_busy, p_wr_en, c_wr_en;
    logic [31:0]            new_count;
    logic [63:0]            new_live, new_sum;
    logic [15:0]            rep_inc;
    logic                   alloc_fail;
    logic [15:0]            align_mask;

    ath_table #(.DEPTH(PTR_ENTRIES), .DATA_W(PTR_DATA_W)) u_ptr (
        .aclk(aclk), .aresetn(aresetn),
        .rd_en(state_reg == S_PREAD), .rd_addr(ppos_reg), .cmp_key(addr_reg),
        .rd_look(p_look), .rd_data(p_rd_data),
        .wr_en(p_wr_en), .wr_addr(ppos_reg), .wr_key(addr_reg), .wr_data(p_wr_data),
        .busy(p_busy)
    );

    ath_table #(.DEPTH(CALLER_ENTRIES), .DATA_W(CALL_DATA_W)) u_caller (
        .aclk(aclk), .aresetn(aresetn),
        .rd_en(state_reg == S_CREAD), .rd_addr(cpos_reg), .cmp_key(key_reg),
        .rd_look(c_look), .rd_data(c_rd_data),
        .wr_en(c_wr_en), .wr_addr(cpos_reg), .wr_key(key_reg), .wr_data(c_wr_data),
        .busy(c_busy)
    );

    assign s_tready = (state_reg == S_IDLE) && !p_busy && !c_busy && !mod_busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign align_mask = (16'd1 << align_reg) - 16'd1;
    assign alloc_fail = (off_reg > {16'd0, heap_bytes_reg})
                     || ({31'd0, need_reg} > ({16'd0, heap_bytes_reg} - off_reg));

    assign new_count = cmd_reg ? cap_count_reg : cap_count_reg + 32'd1;
    assign new_live  = cmd_reg ? cap_live_reg - {32'd0, pbytes_reg}
                               : cap_live_reg + {32'd0, nbytes_reg};
    assign new_sum   = cmd_reg ? cap_sum_reg : cap_sum_reg + {32'd0, nbytes_reg};
    assign rep_inc   = rep_cnt_reg + 16'd1;
    assign mod_t     = {mod_rem_reg, mod_dvd_reg[31]};

    assign p_wr_en   = (state_reg == S_COMMIT) && !cmd_reg;
    assign p_wr_data = {caller_reg, nbytes_reg};
    assign c_wr_en   = (state_reg == S_COMMIT);
    assign c_wr_data = {new_count, new_live, new_sum};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid && s_tready) state_next = S_CHK0;
            S_CHK0:  state_next = S_CHK1;
            S_CHK1: begin
                if (cmd_reg) begin
                    state_next = (rel_reg >= off_reg) ? S_OUT : S_PHASH;
                end else if (alloc_fail || ptr_used_reg == PTR_FULL
                             || caller_used_reg == CALL_FULL) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:  state_next = S_PHASH;
            S_PHASH: state_next = S_PREAD;
            S_PREAD: state_next = S_PCHK;
            S_PCHK: begin
                if (p_look.hit) begin
                    state_next = cmd_reg ? S_CHASH : S_OUT;
                end else if (!p_look.valid) begin
                    state_next = cmd_reg ? S_OUT : S_CHASH;
                end else if (&pcnt_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_PREAD;
                end
            end
            S_CHASH: state_next = S_CREAD;
            S_CREAD: state_next = S_CCHK;
            S_CCHK: begin
                if (c_look.hit) begin
                    state_next = S_COMMIT;
                end else if (!c_look.valid) begin
                    state_next = cmd_reg ? S_OUT : S_COMMIT;
                end else if (&ccnt_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_CREAD;
                end
            end
            S_COMMIT: state_next = S_OUT;
            S_OUT:    if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath, counters and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg   <= '0;
            heap_bytes_reg  <= HEAP_BYTES_RST;
            interval_reg    <= INTERVAL_RST;
            bump_reg        <= '0;
            ptr_used_reg    <= '0;
            caller_used_reg <= '0;
            gcount_reg      <= '0;
            glive_reg       <= '0;
            gsum_reg        <= '0;
            bad_reg         <= '0;
            rep_cnt_reg     <= '0;
            mod_busy_reg    <= 1'b0;
            mod_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_HEAP_BASE: begin
                        heap_base_reg <= cfg_wdata;
                        bump_reg      <= cfg_wdata;
                    end
                    REG_HEAP_BYTES: heap_bytes_reg <= cfg_wdata[47:0];
                    REG_INTERVAL: begin
                        interval_reg <= cfg_wdata[15:0];
                        // realign report counter to grand_count mod interval
                        mod_busy_reg <= (cfg_wdata[15:0] != 16'd0);
                        mod_cnt_reg  <= '0;
                        mod_rem_reg  <= '0;
                        mod_dvd_reg  <= gcount_reg;
                    end
                    default: ;
                endcase
            end else if (mod_busy_reg) begin
                mod_dvd_reg <= {mod_dvd_reg[30:0], 1'b0};
                mod_cnt_reg <= mod_cnt_reg + 5'd1;
                if (mod_t >= {1'b0, interval_reg}) begin
                    mod_rem_reg <= 16'(mod_t - {1'b0, interval_reg});
                end else begin
                    mod_rem_reg <= mod_t[15:0];
                end
                if (&mod_cnt_reg) begin
                    mod_busy_reg <= 1'b0;
                    rep_cnt_reg  <= (mod_t >= {1'b0, interval_reg})
                                  ? 16'(mod_t - {1'b0, interval_reg}) : mod_t[15:0];
                end
            end

            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    cmd_reg    <= s_tuser[0];
                    caller_reg <= s_tdata[63:0];
                    nbytes_reg <= s_tdata[95:64];
                    align_reg  <= s_tdata[99:96];
                    faddr_reg  <= s_tdata[163:100];
                    r_status_reg  <= ST_OK;
                    r_granted_reg <= '0;
                    r_ct_reg      <= '0;
                    r_co_reg      <= '0;
                    r_ca_reg      <= '0;
                    r_due_reg     <= 1'b0;
                end
                S_CHK0: begin
                    off_reg  <= bump_reg - heap_base_reg;
                    rel_reg  <= faddr_reg - heap_base_reg;
                    addr_reg <= faddr_reg;
                    pad_reg  <= (16'd0 - bump_reg[15:0]) & align_mask;
                    need_reg <= {17'd0, (16'd0 - bump_reg[15:0]) & align_mask}
                              + {1'b0, nbytes_reg};
                end
                S_CHK1: begin
                    if (cmd_reg) begin
                        if (rel_reg >= off_reg) begin
                            bad_reg      <= bad_reg + 32'd1;
                            r_status_reg <= ST_FOREIGN;
                        end
                    end else if (alloc_fail) begin
                        r_status_reg <= ST_EXHAUSTED;
                    end else if (ptr_used_reg == PTR_FULL || caller_used_reg == CALL_FULL) begin
                        r_status_reg <= ST_FULL;
                    end
                end
                S_ADDR: addr_reg <= bump_reg + {48'd0, pad_reg};
                S_PHASH: begin
                    ppos_reg <= PIW'(addr_reg[PIW-1:0] * PMUL);
                    pcnt_reg <= '0;
                end
                S_PCHK: begin
                    if (p_look.hit) begin
                        if (cmd_reg) begin
                            pbytes_reg <= p_rd_data[31:0];
                            key_reg    <= p_rd_data[95:32];
                        end else begin
                            r_status_reg <= ST_TRACKED;
                        end
                    end else if (!p_look.valid) begin
                        if (cmd_reg) begin
                            r_status_reg <= ST_UNKNOWN;
                        end else begin
                            key_reg <= caller_reg;
                        end
                    end else if (&pcnt_reg) begin
                        r_status_reg <= cmd_reg ? ST_UNKNOWN : ST_FULL;
                    end else begin
                        ppos_reg <= ppos_reg + PIW'(1);
                        pcnt_reg <= pcnt_reg + PIW'(1);
                    end
                end
                S_CHASH: begin
                    cpos_reg <= CIW'(key_reg[CIW-1:0] * CMUL);
                    ccnt_reg <= '0;
                end
                S_CCHK: begin
                    cnew_reg      <= !c_look.valid;
                    cap_count_reg <= c_look.valid ? c_rd_data[159:128] : 32'd0;
                    cap_live_reg  <= c_look.valid ? c_rd_data[127:64] : 64'd0;
                    cap_sum_reg   <= c_look.valid ? c_rd_data[63:0] : 64'd0;
                    if (!c_look.hit && !c_look.valid && cmd_reg) begin
                        r_status_reg <= ST_UNKNOWN;
                    end else if (!c_look.hit && c_look.valid) begin
                        if (&ccnt_reg) begin
                            r_status_reg <= cmd_reg ? ST_UNKNOWN : ST_FULL;
                        end else begin
                            cpos_reg <= cpos_reg + CIW'(1);
                            ccnt_reg <= ccnt_reg + CIW'(1);
                        end
                    end
                end
                S_COMMIT: begin
                    r_ct_reg <= new_count;
                    r_co_reg <= new_live;
                    r_ca_reg <= new_sum;
                    if (cmd_reg) begin
                        glive_reg <= glive_reg - {32'd0, pbytes_reg};
                    end else begin
                        r_granted_reg   <= addr_reg;
                        bump_reg        <= addr_reg + {32'd0, nbytes_reg};
                        glive_reg       <= glive_reg + {32'd0, nbytes_reg};
                        gsum_reg        <= gsum_reg + {32'd0, nbytes_reg};
                        gcount_reg      <= gcount_reg + 32'd1;
                        ptr_used_reg    <= ptr_used_reg + (PIW+1)'(1);
                        caller_used_reg <= caller_used_reg + (CIW+1)'(cnew_reg);
                        // grand count wrapping to zero is a multiple of any interval
                        if (&gcount_reg || rep_inc == interval_reg) begin
                            rep_cnt_reg <= '0;
                            r_due_reg   <= (interval_reg != 16'd0);
                        end else begin
                            rep_cnt_reg <= rep_inc;
                        end
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, r_due_reg, bad_reg, gsum_reg, glive_reg,
                                         gcount_reg, r_ca_reg, r_co_reg, r_ct_reg,
                                         r_granted_reg, r_status_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    `ATH_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `ATH_ASSERT_NOW(a_no_take_in_sweep, p_busy || c_busy, !s_tready, "request during table sweep")
    `ATH_ASSERT_NOW(a_ptr_bound, 1'b1, ptr_used_reg <= PTR_FULL, "pointer count overflow")
    `ATH_ASSERT_NEXT(a_alloc_count, state_reg == S_COMMIT && !cmd_reg,
                     gcount_reg == $past(gcount_reg) + 32'd1, "allocation not counted")
    `ATH_ASSERT_NOW(a_write_ok, p_wr_en, r_status_reg == ST_OK, "table write on failed request")

endmodule

// ===== design/ath_table.sv =====
// Open-addressed table memory: one read and one write port, valid bit per word,
// clearing sweep after reset. Depends on ath_pkg.
module ath_table #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned DATA_W = 96
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [63:0]              cmp_key,
    output ath_pkg::look_t           rd_look,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [63:0]              wr_key,
    input  logic [DATA_W-1:0]        wr_data,
    output logic                     busy
);
    import ath_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned WW = 1 + 64 + DATA_W;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] rd_word_reg;
    logic          clr_busy_reg;
    logic [IW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + IW'(1);
            if (&clr_addr_reg) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= {1'b1, wr_key, wr_data};
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_look.valid = rd_word_reg[WW-1];
    assign rd_look.hit   = rd_word_reg[WW-1] && (rd_word_reg[WW-2 -: 64] == cmp_key);
    assign rd_data       = rd_word_reg[DATA_W-1:0];
    assign busy          = clr_busy_reg;

endmodule

// ===== verif/tb_allocation_tracker_hash.sv =====
// Self-checking testbench for allocation_tracker_hash: allocate/free requests are
// driven on the input stream and every result is checked against an in-bench model.
// Depends on ath_pkg and the allocation_tracker_hash RTL.
module tb_allocation_tracker_hash;
    timeunit 1ns;
    timeprecision 1ps;
    import ath_pkg::*;

    localparam int PTR_N      = PTR_ENTRIES_DEF;
    localparam int CALLER_N   = CALLER_ENTRIES_DEF;
    localparam int CYCLE_CAP  = 4000000;
    localparam int MAX_REPORT = 10;

    typedef enum bit {CMD_ALLOC = 1'b0, CMD_FREE = 1'b1} cmd_t;

    typedef struct {
        cmd_t        cmd;
        logic [63:0] caller;
        logic [31:0] nbytes;
        logic [3:0]  align;
        logic [63:0] addr;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] granted;
        logic [31:0] c_times;
        logic [63:0] c_live;
        logic [63:0] c_sum;
        logic [31:0] g_times;
        logic [63:0] g_live;
        logic [63:0] g_sum;
        logic [31:0] foreign;
        logic        due;
    } rsp_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    allocation_tracker_hash uut (.*);

    // mirror of the block's configuration and state
    logic [63:0] base_r, bump;
    logic [47:0] heap_sz;
    logic [15:0] interval_r;
    logic [63:0] ptr_k [PTR_N];
    bit          ptr_v [PTR_N];
    logic [63:0] ptr_own [PTR_N];
    logic [31:0] ptr_len [PTR_N];
    int          ptrs_used;
    logic [63:0] cal_k [CALLER_N];
    bit          cal_v [CALLER_N];
    logic [31:0] cal_cnt [CALLER_N];
    logic [63:0] cal_live [CALLER_N];
    logic [63:0] cal_sum [CALLER_N];
    int          callers_used;
    logic [31:0] g_cnt, bad_frees;
    logic [63:0] g_live, g_sum;

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    logic [63:0] granted_addrs[$];
    logic [63:0] caller_pool[40];
    req_t        cur_req;
    int          tx_gap = 0, rx_gap = 0, rx_hold = 0;
    bit          calm = 0;
    int          errors = 0, checked = 0, cycles = 0;
    int          status_seen[6];

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_rsps.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // first slot that is empty or holds the key; depth if none
    function automatic int find_slot(bit in_callers, logic [63:0] key);
        int          depth;
        int          pos;
        logic [63:0] prod;
        depth = in_callers ? CALLER_N : PTR_N;
        prod  = key * 64'd699343;
        pos   = int'(prod % depth);
        for (int i = 0; i < depth; i++) begin
            if (in_callers) begin
                if (!cal_v[pos] || cal_k[pos] == key) return pos;
            end else begin
                if (!ptr_v[pos] || ptr_k[pos] == key) return pos;
            end
            pos = (pos + 1) % depth;
        end
        return depth;
    endfunction

    function automatic rsp_t track_request(req_t r);
        rsp_t        o;
        logic [63:0] align, off, pad, addr, used;
        int          ps, cs;
        o = '{status: ST_OK, default: '0};
        if (r.cmd == CMD_ALLOC) begin
            align = 64'd1 << r.align;
            off   = bump - base_r;
            pad   = (align - (bump & (align - 1))) & (align - 1);
            if (off > {16'd0, heap_sz} || pad + r.nbytes > {16'd0, heap_sz} - off) begin
                o.status = ST_EXHAUSTED;
            end else if (callers_used >= CALLER_N || ptrs_used >= PTR_N) begin
                o.status = ST_FULL;
            end else begin
                addr = bump + pad;
                ps   = find_slot(0, addr);
                cs   = find_slot(1, r.caller);
                if (ps >= PTR_N || cs >= CALLER_N) begin
                    o.status = ST_FULL;
                end else if (ptr_v[ps]) begin
                    o.status = ST_TRACKED;
                end else begin
                    bump   = addr + r.nbytes;
                    g_live = g_live + r.nbytes;
                    g_sum  = g_sum + r.nbytes;
                    g_cnt  = g_cnt + 1;
                    if (!cal_v[cs]) begin
                        cal_v[cs] = 1;
                        cal_k[cs] = r.caller;
                        callers_used++;
                    end
                    cal_live[cs] = cal_live[cs] + r.nbytes;
                    cal_sum[cs]  = cal_sum[cs] + r.nbytes;
                    cal_cnt[cs]  = cal_cnt[cs] + 1;
                    ptr_v[ps]   = 1;
                    ptr_k[ps]   = addr;
                    ptr_own[ps] = r.caller;
                    ptr_len[ps] = r.nbytes;
                    ptrs_used++;
                    o.granted = addr;
                    o.c_times = cal_cnt[cs];
                    o.c_live  = cal_live[cs];
                    o.c_sum   = cal_sum[cs];
                    o.due     = interval_r != 0 && (g_cnt % interval_r) == 0;
                    granted_addrs.push_back(addr);
                    if (granted_addrs.size() > 256) void'(granted_addrs.pop_front());
                end
            end
        end else begin
            used = bump - base_r;
            if (r.addr - base_r >= used) begin
                bad_frees = bad_frees + 1;
                o.status  = ST_FOREIGN;
            end else begin
                ps = find_slot(0, r.addr);
                if (ps >= PTR_N || !ptr_v[ps]) begin
                    o.status = ST_UNKNOWN;
                end else begin
                    cs = find_slot(1, ptr_own[ps]);
                    if (cs >= CALLER_N || !cal_v[cs]) begin
                        o.status = ST_UNKNOWN;
                    end else begin
                        cal_live[cs] = cal_live[cs] - ptr_len[ps];
                        g_live       = g_live - ptr_len[ps];
                        o.c_times = cal_cnt[cs];
                        o.c_live  = cal_live[cs];
                        o.c_sum   = cal_sum[cs];
                    end
                end
            end
        end
        o.g_times = g_cnt;
        o.g_live  = g_live;
        o.g_sum   = g_sum;
        o.foreign = bad_frees;
        return o;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_rsps.push_back(track_request(cur_req));
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req  = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.cmd;
                    s_tdata  <= {4'd0, cur_req.addr, cur_req.align, cur_req.nbytes,
                                 cur_req.caller};
                    if (!calm && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 11);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge aclk) begin
        if (rx_hold > 0) rx_hold <= rx_hold - 1;
    end

    // result monitor
    always @(posedge aclk) begin
        rsp_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status  = status_t'(m_tdata[2:0]);
                got.granted = m_tdata[66:3];
                got.c_times = m_tdata[98:67];
                got.c_live  = m_tdata[162:99];
                got.c_sum   = m_tdata[226:163];
                got.g_times = m_tdata[258:227];
                got.g_live  = m_tdata[322:259];
                got.g_sum   = m_tdata[386:323];
                got.foreign = m_tdata[418:387];
                got.due     = m_tdata[419];
                if (expected_rsps.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORT) $display("unexpected result %p", got);
                end else begin
                    want = expected_rsps.pop_front();
                    checked++;
                    if (got.status <= ST_UNKNOWN) status_seen[got.status]++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= MAX_REPORT)
                            $display("mismatch on result %0d\n  exp %p\n  got %p",
                                     checked, want, got);
                    end
                end
            end
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 11);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_HEAP_BASE: begin
                base_r = val;
                bump   = val;
            end
            REG_HEAP_BYTES: heap_sz = val[47:0];
            default: interval_r = val[15:0];
        endcase
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic req_t make_alloc(logic [63:0] caller, logic [31:0] n, logic [3:0] al);
        return '{cmd: CMD_ALLOC, caller: caller, nbytes: n, align: al,
                 addr: {$urandom, $urandom}};
    endfunction

    function automatic req_t make_free(logic [63:0] addr);
        return '{cmd: CMD_FREE, caller: {$urandom, $urandom}, nbytes: $urandom,
                 align: 4'($urandom), addr: addr};
    endfunction

    function automatic req_t random_req();
        logic [31:0] n;
        logic [63:0] used;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            case ($urandom_range(0, 19))
                0:       n = $urandom;
                1, 2, 3: n = $urandom_range(0, 65536);
                default: n = $urandom_range(0, 256);
            endcase
            return make_alloc(caller_pool[$urandom_range(0, 39)], n,
                              $urandom_range(0, 3) == 0 ? 4'($urandom) :
                                                          4'($urandom_range(0, 4)));
        end
        used = bump - base_r;
        if (pick < 85 && granted_addrs.size() > 0)
            return make_free(granted_addrs[$urandom_range(0, granted_addrs.size() - 1)]);
        if (pick < 92 && used != 0)
            return make_free(base_r + ({$urandom, $urandom} % used));
        return make_free({$urandom, $urandom});
    endfunction

    task automatic push_random(int count);
        for (int i = 0; i < count; i++) pending_reqs.push_back(random_req());
    endtask

    // the generator below reads the mirror; safe because each phase starts drained
    initial begin
        base_r     = 64'd0;
        bump       = 64'd0;
        heap_sz    = HEAP_BYTES_RST;
        interval_r = INTERVAL_RST;
        ptrs_used = 0;
        callers_used = 0;
        g_cnt = 0;
        g_live = 0;
        g_sum = 0;
        bad_frees = 0;
        foreach (ptr_v[i]) ptr_v[i] = 0;
        foreach (cal_v[i]) begin
            cal_v[i] = 0;
            cal_cnt[i] = 0;
            cal_live[i] = 0;
            cal_sum[i] = 0;
        end
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (caller_pool[i])
            caller_pool[i] = (i < 30) ? 64'(i * 64'h40_1000) : {$urandom, $urandom};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: edges of the fields and every status except full
        pending_reqs.push_back(make_alloc(64'd0, 32'd10, 4'd0));
        pending_reqs.push_back(make_alloc('1, 32'd0, 4'd4));         // zero bytes at 16
        pending_reqs.push_back(make_alloc(64'd7, 32'd5, 4'd0));      // same address again
        pending_reqs.push_back(make_alloc(64'd7, 32'hFFFF_FFFF, 4'd0)); // too large
        pending_reqs.push_back(make_alloc(64'd7, 32'd100, 4'd12));
        pending_reqs.push_back(make_alloc(64'd9, 32'd1, 4'd13));
        pending_reqs.push_back(make_alloc('1, 32'd3, 4'd15));
        pending_reqs.push_back(make_alloc(64'h8000_0000_0000_0000, 32'd64, 4'd1));
        pending_reqs.push_back(make_free(64'd0));
        pending_reqs.push_back(make_free(64'd0));                    // double free
        pending_reqs.push_back(make_free(64'd3));                    // inside, untracked
        pending_reqs.push_back(make_free('1));                       // outside
        pending_reqs.push_back(make_free(64'd16));                   // zero-byte block
        pending_reqs.push_back(make_free(64'd4096));
        wait_drained();
        pending_reqs.push_back(make_free(bump));                     // one past the end
        pending_reqs.push_back(make_free(bump - 1));
        wait_drained();

        // wrapping heap near the top of the address space, long receiver hold-off
        write_reg(REG_INTERVAL, 64'd1);
        write_reg(REG_HEAP_BYTES, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_HEAP_BASE, 64'hFFFF_FFFF_FFFF_F000);
        rx_hold = 400;
        push_random(250);
        wait_drained();

        // tight heap, exhaustion is common
        write_reg(REG_HEAP_BASE, {$urandom, $urandom});
        write_reg(REG_HEAP_BYTES, 64'd20000);
        write_reg(REG_INTERVAL, 64'd65535);
        push_random(250);
        wait_drained();

        write_reg(REG_HEAP_BYTES, 64'd0);
        write_reg(REG_INTERVAL, 64'd0);
        push_random(50);
        wait_drained();

        write_reg(REG_HEAP_BASE, 64'h1000);
        write_reg(REG_HEAP_BYTES, 64'd1_000_000_000_000);
        write_reg(REG_INTERVAL, 64'd7);
        push_random(300);
        wait_drained();

        // no idling from here; flood distinct callers until the caller table is full
        calm = 1;
        push_random(100);
        for (int i = 0; i < 1040; i++)
            pending_reqs.push_back(make_alloc({$urandom, $urandom}, 32'd1,
                                              4'($urandom_range(0, 2))));
        push_random(60);
        wait_drained();
        repeat (60) @(posedge aclk);

        $display("checked %0d results: ok %0d, foreign %0d, exhausted %0d, full %0d,",
                 checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("  tracked %0d, unknown %0d; %0d callers, %0d pointers recorded",
                 status_seen[4], status_seen[5], callers_used, ptrs_used);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
